@@ rtl/egc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator group controller package
// Sizes, codes and the per-car record of the controller; the status checker and testbench share the sizes and codes.
// ----------------------------------------------------------------------------
package egc_pkg;

  localparam int CARS   = 2;
  localparam int FLOORS = 16;

  localparam int CAR_W = (CARS > 1) ? $clog2(CARS) : 1;
  localparam int POS_W = $clog2(FLOORS);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_HALL  = 2'd1;
  localparam logic [1:0] OP_CABIN = 2'd2;

  typedef enum logic [1:0] {
    HEAD_UP   = 2'd0,
    HEAD_DOWN = 2'd1,
    HEAD_IDLE = 2'd2
  } head_t;

  typedef enum logic [1:0] {
    MOT_IDLE    = 2'd0,
    MOT_MOVING  = 2'd1,
    MOT_STOPPED = 2'd2
  } motion_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    head_t             head;
    motion_t           motion;
    logic              door;
    logic [FLOORS-1:0] up;
    logic [FLOORS-1:0] down;
  } car_t;

  localparam int CAR_BITS = $bits(car_t);

  localparam car_t RESET_CAR = '{
    pos:    '0,
    head:   HEAD_IDLE,
    motion: MOT_IDLE,
    door:   1'b0,
    up:     '0,
    down:   '0
  };

endpackage

@@ rtl/egc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module egc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/elevator_group_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator group controller
// Nearest-car dispatch under collective control, car state held in a RAM.
// ----------------------------------------------------------------------------
// One request at a time is taken while busy is low. Each car's record sits in
// one RAM entry. A tick visits each car in turn, with a read state and then a
// modify and write-back state, and gives one result per car, the last marked
// by out_last. A hall call reads every car to choose one and then reads and
// updates the chosen car, giving one result. A cabin call reads and updates
// the named car, giving one result. A request with an unused op, a floor
// beyond the building or an unknown car gives no result and leaves busy low.
// Results appear on the cycle after the write-back, for one cycle, and must be
// taken as they come.
// ----------------------------------------------------------------------------
module elevator_group_controller
  import egc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [3:0] in_floor,
  input  logic       in_hall_direction,
  input  logic       in_car,
  output logic       out_valid,
  output logic       out_car_index,
  output logic [3:0] out_car_floor,
  output logic [1:0] out_travel_direction,
  output logic [1:0] out_motion,
  output logic       out_door_open,
  output logic       out_assigned,
  output logic       out_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TREAD,
    S_TMOD,
    S_HREAD,
    S_HCMP,
    S_AREAD,
    S_AMOD
  } state_t;

  localparam logic [CAR_W-1:0] LAST_CAR = CAR_W'(CARS - 1);

  state_t             state_r;
  logic [CAR_W-1:0]   cnt_r;
  logic [CAR_W-1:0]   tgt_r;
  logic [1:0]         op_r;
  logic [POS_W-1:0]   floor_r;
  logic               dir_r;
  logic [CARS-1:0]    valid_r;
  logic               rd_valid_r;

  logic               fok_r;
  logic [CAR_W-1:0]   bok_r;
  logic [POS_W-1:0]   bokd_r;
  logic               fany_r;
  logic [CAR_W-1:0]   bany_r;
  logic [POS_W-1:0]   banyd_r;

  logic               fok_nxt;
  logic [CAR_W-1:0]   bok_nxt;
  logic [POS_W-1:0]   bokd_nxt;
  logic               fany_nxt;
  logic [CAR_W-1:0]   bany_nxt;
  logic [POS_W-1:0]   banyd_nxt;

  logic               ram_we;
  logic [CAR_W-1:0]   ram_waddr;
  logic [CAR_W-1:0]   ram_raddr;
  logic [CAR_BITS-1:0] ram_wdata;
  logic [CAR_BITS-1:0] ram_rdata;

  car_t               cur;
  car_t               ticked;
  car_t               added;
  logic [POS_W-1:0]   car_gap;
  logic               ok;
  head_t              want;
  logic               accept;
  logic               floor_bad;
  logic               car_bad;

  function automatic logic [POS_W-1:0] lowest_bit(input logic [FLOORS-1:0] m);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int i = FLOORS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = POS_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [POS_W-1:0] highest_bit(input logic [FLOORS-1:0] m);
    logic [POS_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (m[i]) begin
        idx = POS_W'(i);
      end
    end
    return idx;
  endfunction

  // Moves one floor toward the target and opens the door on arrival.
  function automatic car_t serve(input car_t s, input logic [POS_W-1:0] target,
                                 input logic use_up);
    car_t r;
    r = s;
    r.motion = MOT_MOVING;
    if (s.pos < target) begin
      r.pos = s.pos + POS_W'(1);
    end else if (s.pos > target) begin
      r.pos = s.pos - POS_W'(1);
    end
    if (r.pos == target) begin
      if (use_up) begin
        r.up[target] = 1'b0;
      end else begin
        r.down[target] = 1'b0;
      end
      r.door   = 1'b1;
      r.motion = MOT_STOPPED;
    end
    return r;
  endfunction

  function automatic car_t tick_car(input car_t s);
    car_t r;
    r = s;
    if (s.door) begin
      r.door = 1'b0;
    end else begin
      case (s.head)
        HEAD_UP: begin
          if (s.up != '0) begin
            r = serve(s, lowest_bit(s.up), 1'b1);
          end else if (s.down != '0) begin
            r.head = HEAD_DOWN;
          end else begin
            r.head   = HEAD_IDLE;
            r.motion = MOT_IDLE;
          end
        end
        HEAD_DOWN: begin
          if (s.down != '0) begin
            r = serve(s, highest_bit(s.down), 1'b0);
          end else if (s.up != '0) begin
            r.head = HEAD_UP;
          end else begin
            r.head   = HEAD_IDLE;
            r.motion = MOT_IDLE;
          end
        end
        default: begin
          r = s;
        end
      endcase
    end
    return r;
  endfunction

  function automatic car_t add_stop(input car_t s, input logic [POS_W-1:0] fl);
    car_t r;
    r = s;
    if (fl != s.pos) begin
      if (fl > s.pos) begin
        r.up[fl] = 1'b1;
      end else begin
        r.down[fl] = 1'b1;
      end
      if (s.head == HEAD_IDLE) begin
        r.head   = (fl > s.pos) ? HEAD_UP : HEAD_DOWN;
        r.motion = MOT_MOVING;
      end
    end
    return r;
  endfunction

  egc_ram #(
    .WIDTH (CAR_BITS),
    .DEPTH (CARS)
  ) u_car_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign floor_bad = 32'(in_floor) >= 32'(FLOORS);
  assign car_bad   = 32'(in_car) >= 32'(CARS);

  // Entries not yet written since reset read as the reset record.
  assign cur     = rd_valid_r ? car_t'(ram_rdata) : RESET_CAR;
  assign ticked  = tick_car(cur);
  assign added   = add_stop(cur, floor_r);
  assign want    = dir_r ? HEAD_DOWN : HEAD_UP;
  assign ok      = (cur.head == HEAD_IDLE) || (cur.head == want);
  assign car_gap = (cur.pos > floor_r) ? (cur.pos - floor_r) : (floor_r - cur.pos);

  assign ram_raddr = (state_r == S_AREAD) ? tgt_r : cnt_r;
  assign ram_we    = (state_r == S_TMOD) || (state_r == S_AMOD);
  assign ram_waddr = (state_r == S_AMOD) ? tgt_r : cnt_r;
  assign ram_wdata = (state_r == S_AMOD) ? CAR_BITS'(added) : CAR_BITS'(ticked);

  always_comb begin
    fok_nxt   = fok_r;
    bok_nxt   = bok_r;
    bokd_nxt  = bokd_r;
    fany_nxt  = fany_r;
    bany_nxt  = bany_r;
    banyd_nxt = banyd_r;
    if (ok && (!fok_r || car_gap < bokd_r)) begin
      fok_nxt  = 1'b1;
      bok_nxt  = cnt_r;
      bokd_nxt = car_gap;
    end
    if (!fany_r || car_gap < banyd_r) begin
      fany_nxt  = 1'b1;
      bany_nxt  = cnt_r;
      banyd_nxt = car_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      out_valid  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      // A result leaves on the cycle after each write-back.
      out_valid  <= (state_r == S_TMOD) || (state_r == S_AMOD);
      rd_valid_r <= valid_r[ram_raddr];
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            floor_r <= POS_W'(in_floor);
            dir_r   <= in_hall_direction;
            tgt_r   <= CAR_W'(in_car);
            cnt_r   <= '0;
            fok_r   <= 1'b0;
            fany_r  <= 1'b0;
            case (in_op)
              OP_TICK:  state_r <= S_TREAD;
              OP_HALL:  state_r <= floor_bad ? S_IDLE : S_HREAD;
              OP_CABIN: state_r <= (floor_bad || car_bad) ? S_IDLE : S_AREAD;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_TREAD: begin
          state_r <= S_TMOD;
        end
        S_TMOD: begin
          out_car_index        <= 1'(cnt_r);
          out_car_floor        <= 4'(ticked.pos);
          out_travel_direction <= ticked.head;
          out_motion           <= ticked.motion;
          out_door_open        <= ticked.door;
          out_assigned         <= 1'b0;
          out_last             <= (cnt_r == LAST_CAR);
          if (cnt_r == LAST_CAR) begin
            state_r <= S_IDLE;
          end else begin
            cnt_r   <= cnt_r + CAR_W'(1);
            state_r <= S_TREAD;
          end
        end
        S_HREAD: begin
          state_r <= S_HCMP;
        end
        S_HCMP: begin
          fok_r   <= fok_nxt;
          bok_r   <= bok_nxt;
          bokd_r  <= bokd_nxt;
          fany_r  <= fany_nxt;
          bany_r  <= bany_nxt;
          banyd_r <= banyd_nxt;
          if (cnt_r == LAST_CAR) begin
            tgt_r   <= fok_nxt ? bok_nxt : bany_nxt;
            state_r <= S_AREAD;
          end else begin
            cnt_r   <= cnt_r + CAR_W'(1);
            state_r <= S_HREAD;
          end
        end
        S_AREAD: begin
          state_r <= S_AMOD;
        end
        S_AMOD: begin
          out_car_index        <= 1'(tgt_r);
          out_car_floor        <= 4'(added.pos);
          out_travel_direction <= added.head;
          out_motion           <= added.motion;
          out_door_open        <= added.door;
          out_assigned         <= (op_r == OP_HALL);
          out_last             <= 1'b1;
          state_r              <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/egc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator group controller checker
// Port-level properties of the controller, attached by a bind statement.
// ----------------------------------------------------------------------------
module egc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_assigned,
  input logic out_last
);

  // A freshly accepted request cannot already have a result on the port.
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe right after a request was accepted");

  // The final result of a request is followed by a quiet cycle.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("result strobe straight after a final result");

  // Only a tick gives more than one result, and tick results are never assigned.
  a_assigned_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_assigned) |-> out_last)
    else $error("hall call result not marked as final");

  // Until its final result the controller stays busy.
  a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("controller idle with results still to come");

endmodule

bind elevator_group_controller egc_checker u_egc_checker (.*);

@@ dv/egc_status_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator group controller status checker
// Watches the request and result channels and keeps its own copy of every car.
// It predicts the car status reports for each accepted request and compares
// every result, field by field, with the oldest report still waiting.
// ----------------------------------------------------------------------------
module egc_status_checker
  import egc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] in_op,
  input  logic [3:0] in_floor,
  input  logic       in_hall_direction,
  input  logic       in_car,
  input  logic       out_valid,
  input  logic       out_car_index,
  input  logic [3:0] out_car_floor,
  input  logic [1:0] out_travel_direction,
  input  logic [1:0] out_motion,
  input  logic       out_door_open,
  input  logic       out_assigned,
  input  logic       out_last,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic       car_index;
    logic [3:0] car_floor;
    head_t      heading;
    motion_t    motion;
    logic       door;
    logic       assigned;
    logic       last;
  } car_status_t;

  logic [POS_W-1:0]  floor_now  [CARS];
  head_t             heading_now[CARS];
  motion_t           motion_now [CARS];
  logic              door_now   [CARS];
  logic [FLOORS-1:0] up_stops   [CARS];
  logic [FLOORS-1:0] down_stops [CARS];

  car_status_t expected_status[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Four-state compare, so an unknown on a result port counts as a mismatch.
  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] wanted);
    if (got !== wanted) begin
      log_mismatch($sformatf("%s is %0d, expected %0d", field, got, wanted));
    end
  endtask

  function automatic int floors_between(input int c, input int fl);
    return (floor_now[c] > fl) ? floor_now[c] - fl : fl - floor_now[c];
  endfunction

  task automatic clear_cars();
    for (int c = 0; c < CARS; c++) begin
      floor_now[c]   = '0;
      heading_now[c] = HEAD_IDLE;
      motion_now[c]  = MOT_IDLE;
      door_now[c]    = 1'b0;
      up_stops[c]    = '0;
      down_stops[c]  = '0;
    end
    expected_status.delete();
  endtask

  // A stop at the car's own floor is dropped; an idle car sets off towards it.
  task automatic place_stop(input int c, input int fl);
    if (fl == floor_now[c]) return;
    if (fl > floor_now[c]) up_stops[c][fl] = 1'b1;
    else down_stops[c][fl] = 1'b1;
    if (heading_now[c] == HEAD_IDLE) begin
      heading_now[c] = (fl > floor_now[c]) ? HEAD_UP : HEAD_DOWN;
      motion_now[c]  = MOT_MOVING;
    end
  endtask

  task automatic travel_to(input int c, input int target, input bit upward);
    motion_now[c] = MOT_MOVING;
    if (floor_now[c] < target) floor_now[c]++;
    else if (floor_now[c] > target) floor_now[c]--;
    if (floor_now[c] == target) begin
      if (upward) up_stops[c][target] = 1'b0;
      else down_stops[c][target] = 1'b0;
      door_now[c]   = 1'b1;
      motion_now[c] = MOT_STOPPED;
    end
  endtask

  task automatic advance_car(input int c);
    int target;
    if (door_now[c]) begin
      door_now[c] = 1'b0;
      return;
    end
    case (heading_now[c])
      HEAD_UP: begin
        if (up_stops[c] != '0) begin
          target = 0;
          while (!up_stops[c][target]) target++;
          travel_to(c, target, 1'b1);
        end else if (down_stops[c] != '0) begin
          heading_now[c] = HEAD_DOWN;
        end else begin
          heading_now[c] = HEAD_IDLE;
          motion_now[c]  = MOT_IDLE;
        end
      end
      HEAD_DOWN: begin
        if (down_stops[c] != '0) begin
          target = FLOORS - 1;
          while (!down_stops[c][target]) target--;
          travel_to(c, target, 1'b0);
        end else if (up_stops[c] != '0) begin
          heading_now[c] = HEAD_UP;
        end else begin
          heading_now[c] = HEAD_IDLE;
          motion_now[c]  = MOT_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_status(input int c, input bit assigned, input bit last);
    car_status_t s;
    s.car_index = c[0];
    s.car_floor = floor_now[c];
    s.heading   = heading_now[c];
    s.motion    = motion_now[c];
    s.door      = door_now[c];
    s.assigned  = assigned;
    s.last      = last;
    expected_status = {expected_status, s};
  endtask

  task automatic predict_request(input logic [1:0] op, input int fl, input logic dir,
                                 input int cab);
    int    best;
    int    best_gap;
    bit    found;
    head_t wanted;
    best     = 0;
    best_gap = 0;
    found    = 1'b0;
    wanted   = dir ? HEAD_DOWN : HEAD_UP;
    case (op)
      OP_TICK: begin
        for (int c = 0; c < CARS; c++) advance_car(c);
        for (int c = 0; c < CARS; c++) queue_status(c, 1'b0, c == CARS - 1);
      end
      OP_HALL: begin
        if (fl < FLOORS) begin
          // Prefer idle cars and cars already heading the caller's way.
          for (int c = 0; c < CARS; c++) begin
            if ((heading_now[c] == HEAD_IDLE || heading_now[c] == wanted) &&
                (!found || floors_between(c, fl) < best_gap)) begin
              found    = 1'b1;
              best     = c;
              best_gap = floors_between(c, fl);
            end
          end
          if (!found) begin
            for (int c = 0; c < CARS; c++) begin
              if (!found || floors_between(c, fl) < best_gap) begin
                found    = 1'b1;
                best     = c;
                best_gap = floors_between(c, fl);
              end
            end
          end
          place_stop(best, fl);
          queue_status(best, 1'b1, 1'b1);
        end
      end
      OP_CABIN: begin
        if (fl < FLOORS && cab < CARS) begin
          place_stop(cab, fl);
          queue_status(cab, 1'b0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_status();
    car_status_t wanted;
    if (expected_status.size() == 0) begin
      log_mismatch($sformatf("result for car %0d with no request waiting", out_car_index));
      return;
    end
    wanted = expected_status.pop_front();
    check_field("car_index", 32'(out_car_index), 32'(wanted.car_index));
    check_field("car_floor", 32'(out_car_floor), 32'(wanted.car_floor));
    check_field("travel_direction", 32'(out_travel_direction), 32'(wanted.heading));
    check_field("motion", 32'(out_motion), 32'(wanted.motion));
    check_field("door_open", 32'(out_door_open), 32'(wanted.door));
    check_field("assigned", 32'(out_assigned), 32'(wanted.assigned));
    check_field("last", 32'(out_last), 32'(wanted.last));
  endtask

  // Results are checked before the new request is predicted, since a result
  // on the same edge always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_cars();
    end else begin
      if (out_valid) check_status();
      if (start && !busy) begin
        predict_request(in_op, int'(in_floor), in_hall_direction, int'(in_car));
      end
    end
    outstanding = expected_status.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevator group controller testbench
// Drives ticks, hall calls and cabin calls in random bursts after a directed
// opening, and leaves the checking of every car status report to the checker.
// ----------------------------------------------------------------------------
module testbench;
  import egc_pkg::*;

  localparam int         STALL_LIMIT     = 2000;
  localparam int         RANDOM_REQUESTS = 220;
  localparam int         SETTLE_CYCLES   = 20;
  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic       CALL_UP         = 1'b0;
  localparam logic       CALL_DOWN       = 1'b1;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_op;
  logic [3:0] in_floor;
  logic       in_hall_direction;
  logic       in_car;
  logic       out_valid;
  logic       out_car_index;
  logic [3:0] out_car_floor;
  logic [1:0] out_travel_direction;
  logic [1:0] out_motion;
  logic       out_door_open;
  logic       out_assigned;
  logic       out_last;

  logic took = 1'b0;
  int   idle_cycles = 0;
  int   mismatches;
  int   outstanding;

  elevator_group_controller u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_floor             (in_floor),
    .in_hall_direction    (in_hall_direction),
    .in_car               (in_car),
    .out_valid            (out_valid),
    .out_car_index        (out_car_index),
    .out_car_floor        (out_car_floor),
    .out_travel_direction (out_travel_direction),
    .out_motion           (out_motion),
    .out_door_open        (out_door_open),
    .out_assigned         (out_assigned),
    .out_last             (out_last)
  );

  egc_status_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_floor             (in_floor),
    .in_hall_direction    (in_hall_direction),
    .in_car               (in_car),
    .out_valid            (out_valid),
    .out_car_index        (out_car_index),
    .out_car_floor        (out_car_floor),
    .out_travel_direction (out_travel_direction),
    .out_motion           (out_motion),
    .out_door_open        (out_door_open),
    .out_assigned         (out_assigned),
    .out_last             (out_last),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Records whether the request on the ports was taken at the last edge.
  always @(posedge clk) begin
    took <= start && !busy;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic issue_request(input logic [1:0] op, input logic [3:0] fl,
                               input logic dir, input logic cab);
    in_op             = op;
    in_floor          = fl;
    in_hall_direction = dir;
    in_car            = cab;
    start             = 1'b1;
    do @(negedge clk); while (!took);
  endtask

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic await_drain();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mostly ticks and calls, with a few requests on the unused code as noise.
  task automatic random_request(output bit counted);
    int         pick;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_TICK;
    else if (pick < 72) op = OP_HALL;
    else if (pick < 95) op = OP_CABIN;
    else op = OP_UNUSED;
    issue_request(op, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    counted = (op != OP_UNUSED);
  endtask

  initial begin
    int served;
    int burst;
    bit counted;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_op             = OP_TICK;
    in_floor          = '0;
    in_hall_direction = CALL_UP;
    in_car            = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    issue_request(OP_TICK, 4'd0, CALL_UP, 1'b0);
    // A stop at the car's own floor, then a request on the unused code.
    issue_request(OP_CABIN, 4'd0, CALL_UP, 1'b0);
    issue_request(OP_UNUSED, 4'd15, CALL_DOWN, 1'b1);
    issue_request(OP_HALL, 4'd0, CALL_UP, 1'b1);
    issue_request(OP_CABIN, 4'd2, CALL_UP, 1'b1);
    issue_request(OP_HALL, 4'd15, CALL_DOWN, 1'b0);
    // Both cars now head up, so a down call falls back to the nearest car.
    issue_request(OP_HALL, 4'd1, CALL_DOWN, 1'b0);
    issue_request(OP_TICK, 4'd15, CALL_DOWN, 1'b1);
    issue_request(OP_TICK, 4'd0, CALL_UP, 1'b0);
    issue_request(OP_CABIN, 4'd0, CALL_DOWN, 1'b1);
    // The second car finishes going up and must turn round for the ground floor.
    repeat (6) issue_request(OP_TICK, 4'd0, CALL_UP, 1'b0);
    issue_request(OP_HALL, 4'd15, CALL_UP, 1'b1);
    issue_request(OP_CABIN, 4'd15, CALL_UP, 1'b1);
    issue_request(OP_HALL, 4'd0, CALL_DOWN, 1'b0);
    issue_request(OP_CABIN, 4'd0, CALL_DOWN, 1'b0);
    await_drain();

    served = 0;
    while (served < RANDOM_REQUESTS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (burst) begin
        random_request(counted);
        served += int'(counted);
      end
      case ($urandom_range(0, 9))
        0: await_drain();
        1, 2: ;
        default: hold_off($urandom_range(1, 12));
      endcase
    end

    await_drain();
    hold_off(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/egc_pkg.sv
rtl/egc_ram.sv
rtl/elevator_group_controller.sv
rtl/egc_checker.sv
dv/egc_status_checker.sv
dv/testbench.sv
